FILE: design/itac_pkg.sv
package itac_pkg;

    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int SAMPLE_W        = 32;
    localparam int COUNT_W         = 11;
    localparam int SUM_W           = 48;
    localparam int DIFF_W          = 33;
    localparam int PROD_W          = 66;
    localparam int ACC_W           = 128;
    localparam int DIV_CNT_W       = 7;
    localparam int FRAC_W          = 16;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_VAR = 2'd1,
        ST_SAT      = 2'd2,
        ST_DROP     = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_in;

    typedef struct packed {
        logic [SAMPLE_W-1:0] tau;
        t_status             status;
        logic [COUNT_W-1:0]  sample_count;
    } t_out;

endpackage

FILE: design/itac_ram.sv
module itac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: design/integrated_autocorrelation_time.sv
// channel | direction | payload          | handshake
// input   | in        | itac_pkg::t_in   | i_in_valid / o_in_ready
// output  | out       | itac_pkg::t_out  | o_out_valid / i_out_ready
//
// samples are taken one beat per cycle and written into two copies of the
// sample memory (one read port each), so two lag taps are read per cycle
// after last: a mean divide, then each lag n costs (N-n) sample pairs of
// memory streaming plus a shared divide, then the final divide
// o_in_ready is low from the last beat until the result enters the output
// register; an unaccepted earlier result holds S_DONE and blocks the next series
// reset (synchronous, active low) clears counts, sums and control only

module integrated_autocorrelation_time #(
    parameter int MAX_SAMPLES = itac_pkg::MAX_SAMPLES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  itac_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output itac_pkg::t_out o_out_data
);

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int FW = $clog2(MAX_SAMPLES + 1);
    localparam int ACC_W = itac_pkg::ACC_W;
    localparam logic [FW-1:0] FILL_MAX = FW'(MAX_SAMPLES);

    typedef enum logic [11:0] {
        S_COLLECT   = 12'b0000_0000_0001,
        S_MEAN_LD   = 12'b0000_0000_0010,
        S_MEAN_DIV  = 12'b0000_0000_0100,
        S_MEAN_POST = 12'b0000_0000_1000,
        S_LAG       = 12'b0000_0001_0000,
        S_LAG_END   = 12'b0000_0010_0000,
        S_G_DIV     = 12'b0000_0100_0000,
        S_G_POST    = 12'b0000_1000_0000,
        S_T_LD      = 12'b0001_0000_0000,
        S_T_DIV     = 12'b0010_0000_0000,
        S_T_POST    = 12'b0100_0000_0000,
        S_DONE      = 12'b1000_0000_0000
    } t_state;

    // control
    t_state r_state, n_state;
    logic [FW-1:0] r_fill, n_fill;
    logic signed [itac_pkg::SUM_W-1:0] r_sum, n_sum;
    logic r_ovf, n_ovf;
    logic [itac_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [FW-1:0] r_lag, n_lag;
    logic [FW-1:0] r_iss, n_iss;
    logic r_v1, n_v1, r_v2, n_v2, r_v3, n_v3;
    logic r_out_valid, n_out_valid;

    // datapath
    logic [ACC_W-1:0] r_num, n_num;     // dividend, shifts into quotient
    logic [ACC_W-1:0] r_rem, n_rem;
    logic [ACC_W-1:0] r_den, n_den;
    logic r_sign, n_sign;
    logic signed [itac_pkg::DIFF_W-1:0] r_mean, n_mean;
    logic signed [itac_pkg::DIFF_W-1:0] r_dx, n_dx, r_dy, n_dy;
    logic signed [itac_pkg::PROD_W-1:0] r_prod, n_prod;
    logic [ACC_W-1:0] r_acc, n_acc;     // two's complement lag sum
    logic [ACC_W-1:0] r_g0, n_g0;
    logic [ACC_W-1:0] r_total, n_total;
    itac_pkg::t_out r_pend, n_pend;
    itac_pkg::t_out r_res, n_res;

    // memory ports
    logic ram_we;
    logic [AW-1:0] ram_waddr, addr_a, addr_b;
    logic [itac_pkg::SAMPLE_W-1:0] rd_a, rd_b;
    logic [FW-1:0] tap_b;
    logic issue;

    // divider step
    logic [ACC_W-1:0] rem_sh;
    logic div_ge;
    logic [itac_pkg::SUM_W-1:0] sum_mag;

    assign o_in_ready  = (r_state == S_COLLECT);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_res;

    assign ram_we    = o_in_ready && i_in_valid && (r_fill < FILL_MAX);
    assign ram_waddr = r_fill[AW-1:0];
    assign tap_b     = r_iss + r_lag;
    assign addr_a    = r_iss[AW-1:0];
    assign addr_b    = tap_b[AW-1:0];
    assign issue     = (r_state == S_LAG) && (r_iss < (r_fill - r_lag));

    assign rem_sh  = {r_rem[ACC_W-2:0], r_num[ACC_W-1]};
    assign div_ge  = (rem_sh >= r_den);
    assign sum_mag = r_sum[itac_pkg::SUM_W-1] ? itac_pkg::SUM_W'(-r_sum)
                                             : itac_pkg::SUM_W'(r_sum);

    itac_ram #(.WIDTH(itac_pkg::SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in_data.sample),
        .i_raddr (addr_a),
        .o_rdata (rd_a)
    );

    itac_ram #(.WIDTH(itac_pkg::SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in_data.sample),
        .i_raddr (addr_b),
        .o_rdata (rd_b)
    );

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_sum       = r_sum;
        n_ovf       = r_ovf;
        n_cnt       = r_cnt;
        n_lag       = r_lag;
        n_iss       = r_iss;
        n_num       = r_num;
        n_rem       = r_rem;
        n_den       = r_den;
        n_sign      = r_sign;
        n_mean      = r_mean;
        n_g0        = r_g0;
        n_total     = r_total;
        n_pend      = r_pend;
        n_res       = r_res;
        n_acc       = r_acc;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // lag product pipeline: read, center, multiply, accumulate
        n_v1   = 1'b0;
        n_v2   = r_v1;
        n_v3   = r_v2;
        n_dx   = itac_pkg::DIFF_W'(34'($signed(rd_a)) - 34'(r_mean));
        n_dy   = itac_pkg::DIFF_W'(34'($signed(rd_b)) - 34'(r_mean));
        n_prod = r_dx * r_dy;
        if (r_v3) begin
            n_acc = r_acc + ACC_W'(r_prod);
        end

        case (r_state)
            S_COLLECT: begin
                if (i_in_valid) begin
                    if (r_fill < FILL_MAX) begin
                        n_fill = r_fill + 1'b1;
                        n_sum  = r_sum + itac_pkg::SUM_W'(i_in_data.sample);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_data.last) begin
                        n_state = S_MEAN_LD;
                    end
                end
            end
            S_MEAN_LD: begin
                n_sign  = r_sum[itac_pkg::SUM_W-1];
                n_num   = ACC_W'(sum_mag);
                n_den   = ACC_W'(r_fill);
                n_rem   = '0;
                n_cnt   = '1;
                n_state = S_MEAN_DIV;
            end
            S_MEAN_DIV, S_G_DIV, S_T_DIV: begin
                n_rem = div_ge ? (rem_sh - r_den) : rem_sh;
                n_num = {r_num[ACC_W-2:0], div_ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    case (r_state)
                        S_MEAN_DIV: n_state = S_MEAN_POST;
                        S_G_DIV:    n_state = S_G_POST;
                        default:    n_state = S_T_POST;
                    endcase
                end
            end
            S_MEAN_POST: begin
                n_mean  = r_sign ? -$signed(r_num[itac_pkg::DIFF_W-1:0])
                                 : $signed(r_num[itac_pkg::DIFF_W-1:0]);
                n_lag   = '0;
                n_iss   = '0;
                n_acc   = '0;
                n_state = S_LAG;
            end
            S_LAG: begin
                if (issue) begin
                    n_iss = r_iss + 1'b1;
                    n_v1  = 1'b1;
                end else if (!(r_v1 || r_v2 || r_v3)) begin
                    n_state = S_LAG_END;
                end
            end
            S_LAG_END: begin
                // stop before the first lag with negative covariance
                if ((r_lag == '0) || !r_acc[ACC_W-1]) begin
                    n_num   = r_acc;
                    n_den   = ACC_W'(r_fill - r_lag);
                    n_rem   = '0;
                    n_cnt   = '1;
                    n_state = S_G_DIV;
                end else begin
                    n_state = S_T_LD;
                end
            end
            S_G_POST: begin
                if ((r_lag == '0) && (r_num == '0)) begin
                    n_pend.tau          = '0;
                    n_pend.status       = itac_pkg::ST_ZERO_VAR;
                    n_pend.sample_count = itac_pkg::COUNT_W'(r_fill);
                    n_state             = S_DONE;
                end else begin
                    if (r_lag == '0) begin
                        n_g0    = r_num;
                        n_total = r_num >> 1;
                    end else begin
                        n_total = r_total + r_num;
                    end
                    if ((r_lag + 1'b1) < r_fill) begin
                        n_lag   = r_lag + 1'b1;
                        n_iss   = '0;
                        n_acc   = '0;
                        n_state = S_LAG;
                    end else begin
                        n_state = S_T_LD;
                    end
                end
            end
            S_T_LD: begin
                n_num   = r_total << itac_pkg::FRAC_W;
                n_den   = r_g0;
                n_rem   = '0;
                n_cnt   = '1;
                n_state = S_T_DIV;
            end
            S_T_POST: begin
                n_pend.sample_count = itac_pkg::COUNT_W'(r_fill);
                if (r_num[ACC_W-1:itac_pkg::SAMPLE_W] != '0) begin
                    n_pend.tau    = '1;
                    n_pend.status = itac_pkg::ST_SAT;
                end else begin
                    n_pend.tau    = r_num[itac_pkg::SAMPLE_W-1:0];
                    n_pend.status = r_ovf ? itac_pkg::ST_DROP : itac_pkg::ST_OK;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_res       = r_pend;
                    n_out_valid = 1'b1;
                    n_fill      = '0;
                    n_sum       = '0;
                    n_ovf       = 1'b0;
                    n_state     = S_COLLECT;
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_fill      <= '0;
            r_sum       <= '0;
            r_ovf       <= 1'b0;
            r_cnt       <= '0;
            r_lag       <= '0;
            r_iss       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_ovf       <= n_ovf;
            r_cnt       <= n_cnt;
            r_lag       <= n_lag;
            r_iss       <= n_iss;
            r_v1        <= n_v1;
            r_v2        <= n_v2;
            r_v3        <= n_v3;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num   <= n_num;
        r_rem   <= n_rem;
        r_den   <= n_den;
        r_sign  <= n_sign;
        r_mean  <= n_mean;
        r_dx    <= n_dx;
        r_dy    <= n_dy;
        r_prod  <= n_prod;
        r_acc   <= n_acc;
        r_g0    <= n_g0;
        r_total <= n_total;
        r_pend  <= n_pend;
        r_res   <= n_res;
    end

    // store never overfills
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_MAX)
        else $error("fill count beyond capacity");

    // products only reach the accumulator while a lag is streaming
    a_pipe_in_lag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 || r_v2 || r_v3) |-> (r_state == S_LAG))
        else $error("lag pipeline active outside lag phase");

    // zero variance result carries zero tau
    a_zero_var_tau: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.status == itac_pkg::ST_ZERO_VAR)) |-> (r_res.tau == '0))
        else $error("zero variance with nonzero tau");

    // returning to collection always publishes a result
    a_done_publish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && (n_state == S_COLLECT)) |=> r_out_valid)
        else $error("series finished without a result");

endmodule
